[rtl/busy_interval_union_tracker_macros.svh]
// Assertion macros used by the checker file of the busy interval union tracker.
`ifndef BUSY_INTERVAL_UNION_TRACKER_MACROS_SVH
`define BUSY_INTERVAL_UNION_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BIUT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BIUT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/biut_pkg.sv]
// Shared widths, register codes and interface structs of the busy interval union tracker.
package biut_pkg;

  localparam int TIME_W   = 64;
  localparam int CAT_W    = 3;
  localparam int CNT_W    = 16;
  localparam int OUT_CATS = 5;
  localparam int ITEM_W   = 136;
  localparam int RES_W    = 520;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] MIN_ITEMS_RESET = 16'd50;
  localparam logic [CNT_W-1:0] ITEMS_MAX       = 16'hFFFF;

  // Register word indexes on the configuration port.
  localparam logic [ADDR_W-3:0] REG_MIN_ITEMS = 1'b0;

  // One stored interval, closed at both ends.
  typedef struct packed {
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] lo;
  } ivl_t;

  // Request to the interval table engine.
  typedef struct packed {
    logic              start;
    logic              merge;
    logic              sum;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } tbl_cmd_t;

  // Status from the interval table engine.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [TIME_W-1:0] busy_time;
    logic [TIME_W-1:0] span;
  } tbl_sts_t;

  // Request to the running totals.
  typedef struct packed {
    logic              count;
    logic              add;
    logic              clear;
    logic              set_ovf;
    logic [CAT_W-1:0]  cat;
    logic [TIME_W-1:0] len;
  } tot_cmd_t;

endpackage

[rtl/biut_cfg.sv]
// Configuration register block with an APB-style port.
module biut_cfg
  import biut_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  min_items
);

  logic sel_min;

  assign sel_min = (paddr[ADDR_W-1:2] == REG_MIN_ITEMS);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_items <= MIN_ITEMS_RESET;
    end else if (psel && penable && pwrite && pready && sel_min) begin
      min_items <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_min) begin
      prdata = DATA_W'(min_items);
    end
  end

endmodule

[rtl/biut_totals.sv]
// Running batch totals: item count, overlapped sum, category sums and overflow mark.
module biut_totals
  import biut_pkg::*;
#(
  parameter int CATEGORY_COUNT = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tot_cmd_t                              cmd,
  output logic [CNT_W-1:0]                      items_seen,
  output logic [TIME_W-1:0]                     overlap_sum,
  output logic [CATEGORY_COUNT-1:0][TIME_W-1:0] cat_sum,
  output logic                                  overflow_seen
);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      items_seen    <= '0;
      overlap_sum   <= '0;
      cat_sum       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.count && (items_seen != ITEMS_MAX)) begin
        items_seen <= items_seen + 1'b1;
      end
      if (cmd.add) begin
        overlap_sum <= overlap_sum + cmd.len;
      end
      // A category beyond the last one still counts toward the overlapped sum only.
      for (int k = 0; k < CATEGORY_COUNT; k++) begin
        if (cmd.add && (int'(cmd.cat) == k)) begin
          cat_sum[k] <= cat_sum[k] + cmd.len;
        end
      end
      if (cmd.set_ovf) begin
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

[rtl/biut_table.sv]
// Interval table memory with its merge-and-compact scan and its batch-end summing scan.
module biut_table
  import biut_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tbl_cmd_t                             cmd,
  input  logic                                 clear,
  output tbl_sts_t                             sts,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_MERGE  = 3'd1;
  localparam logic [2:0] T_APPEND = 3'd2;
  localparam logic [2:0] T_SUM    = 3'd3;
  localparam logic [2:0] T_SPAN   = 3'd4;

  ivl_t mem [TABLE_DEPTH];

  logic [2:0]        state;
  logic [CW-1:0]     issue;
  logic [CW-1:0]     kept;
  logic [CW-1:0]     total;
  logic              v1;
  logic              v2;
  ivl_t              rdata;
  logic [TIME_W-1:0] lo;
  logic [TIME_W-1:0] hi;
  logic              do_sum;
  logic              have;
  logic [TIME_W-1:0] min_s;
  logic [TIME_W-1:0] max_e;
  logic [TIME_W-1:0] diff_q;
  logic [TIME_W-1:0] busy;
  logic [TIME_W-1:0] span;
  logic              done;
  logic              ovf;

  logic              rd_en;
  logic [AW-1:0]     raddr;
  logic              hit;
  logic              we;
  logic [AW-1:0]     waddr;
  ivl_t              wdata;

  // Reads run ahead of the compaction write pointer, so a read never meets a write.
  always_comb begin
    rd_en = ((state == T_MERGE) || (state == T_SUM)) && (issue < total);
    raddr = issue[AW-1:0];
    hit   = !((rdata.hi < lo) || (hi < rdata.lo));
    we    = 1'b0;
    waddr = kept[AW-1:0];
    wdata = rdata;
    if ((state == T_MERGE) && v1 && !hit) begin
      we = 1'b1;
    end else if ((state == T_APPEND) && (kept < DEPTH_C)) begin
      we       = 1'b1;
      wdata.lo = lo;
      wdata.hi = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      total <= '0;
      issue <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      done  <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      done <= 1'b0;
      ovf  <= 1'b0;
      v1   <= rd_en;
      v2   <= v1 && (state == T_SUM);
      if (rd_en) begin
        issue <= issue + 1'b1;
      end
      if (clear) begin
        total <= '0;
      end
      unique case (state)
        T_IDLE: begin
          if (cmd.start) begin
            issue  <= '0;
            kept   <= '0;
            lo     <= cmd.lo;
            hi     <= cmd.hi;
            do_sum <= cmd.sum;
            have   <= 1'b0;
            busy   <= '0;
            state  <= cmd.merge ? T_MERGE : T_SUM;
          end
        end
        T_MERGE: begin
          if (v1) begin
            if (hit) begin
              if (rdata.lo < lo) lo <= rdata.lo;
              if (rdata.hi > hi) hi <= rdata.hi;
            end else begin
              kept <= kept + 1'b1;
            end
          end
          if (!rd_en && !v1) begin
            state <= T_APPEND;
          end
        end
        T_APPEND: begin
          if (kept < DEPTH_C) begin
            total <= kept + 1'b1;
          end else begin
            total <= kept;
            ovf   <= 1'b1;
          end
          issue <= '0;
          if (do_sum) begin
            state <= T_SUM;
          end else begin
            done  <= 1'b1;
            state <= T_IDLE;
          end
        end
        T_SUM: begin
          if (v1) begin
            diff_q <= rdata.hi - rdata.lo;
            have   <= 1'b1;
            if (!have || (rdata.lo < min_s)) min_s <= rdata.lo;
            if (!have || (rdata.hi > max_e)) max_e <= rdata.hi;
          end
          if (v2) begin
            busy <= busy + diff_q;
          end
          if (!rd_en && !v1 && !v2) begin
            state <= T_SPAN;
          end
        end
        T_SPAN: begin
          span  <= (have && (max_e > min_s)) ? (max_e - min_s) : '0;
          done  <= 1'b1;
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign sts.done      = done;
  assign sts.ovf       = ovf;
  assign sts.busy_time = busy;
  assign sts.span      = span;
  assign count         = total;

endmodule

[rtl/busy_interval_union_tracker.sv]
// Top level of the busy interval union tracker: input stage, sequencing and result register.
//
//   Channel   Handshake              Payload
//   s_*       s_tvalid / s_tready    s_tdata, s_tuser (skip), s_tlast (last of batch)
//   m_*       m_tvalid / m_tready    m_tdata, m_tuser (overflow, valid)
//   p*        psel/penable/pready    paddr, pwdata, prdata (min_items at byte 0)
//
// An item that is not skipped scans the table once, because every stored interval passes
// once through the single read port of the table memory. The last item of a batch adds a
// second scan to sum the table, over the intervals held after the merge, and then loads
// the result. A skipped item that is not last does not start the table. Reset is
// synchronous and active high; the table memory needs no clearing pass since its fill
// count is reset. A stalled result does not hold up new items until another batch end
// needs the result register.
module busy_interval_union_tracker
  import biut_pkg::*;
#(
  parameter int TABLE_DEPTH    = 128,
  parameter int CATEGORY_COUNT = 5
) (
  input  logic              clk,
  input  logic              rst,
  // Input item stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [ITEM_W-1:0] s_tdata,  // start_time[63:0], end_time[127:64], category[130:128]
  input  logic [0:0]        s_tuser,  // skip[0]
  input  logic              s_tlast,
  // Result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [RES_W-1:0]  m_tdata,  // union, span, overlapped, kernel, write, copy, read,
                                      // other (64 bits each), interval_count[519:512]
  output logic [1:0]        m_tuser,  // table_overflow[0], result_valid[1]
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(TABLE_DEPTH+1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]        state;
  logic [TIME_W-1:0] st_q;
  logic [TIME_W-1:0] en_q;
  logic [TIME_W-1:0] len_q;
  logic [CAT_W-1:0]  cat_q;
  logic              skip_q;
  logic              last_q;

  logic              accept;
  logic [TIME_W:0]   diff;
  logic              out_load;

  logic [CNT_W-1:0]                      min_items;
  logic [CNT_W-1:0]                      items_seen;
  logic [TIME_W-1:0]                     overlap_sum;
  logic [CATEGORY_COUNT-1:0][TIME_W-1:0] cat_sum;
  logic                                  overflow_seen;
  logic [OUT_CATS-1:0][TIME_W-1:0]       cat_out;

  tbl_cmd_t          tcmd;
  tbl_sts_t          tsts;
  tot_cmd_t          acmd;
  logic [CW-1:0]     count;

  // Items are taken only between commands; each one is worked on to completion.
  // Nothing is taken while reset is held.
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  // A start later than the end is clamped to the end, giving a zero length.
  assign diff     = {1'b0, s_tdata[2*TIME_W-1:TIME_W]} - {1'b0, s_tdata[TIME_W-1:0]};
  assign out_load = (state == S_FINAL) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      en_q   <= s_tdata[2*TIME_W-1:TIME_W];
      st_q   <= diff[TIME_W] ? s_tdata[2*TIME_W-1:TIME_W] : s_tdata[TIME_W-1:0];
      len_q  <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
      cat_q  <= s_tdata[2*TIME_W+CAT_W-1:2*TIME_W];
      skip_q <= s_tuser[0];
      last_q <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_LOAD;
        end
        S_LOAD: begin
          state <= (!skip_q || last_q) ? S_WAIT : S_IDLE;
        end
        S_WAIT: begin
          if (tsts.done) state <= last_q ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          if (out_load) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    tcmd.start = (state == S_LOAD) && (!skip_q || last_q);
    tcmd.merge = !skip_q;
    tcmd.sum   = last_q;
    tcmd.lo    = st_q;
    tcmd.hi    = en_q;

    acmd.count   = accept;
    acmd.add     = (state == S_LOAD) && !skip_q;
    acmd.clear   = out_load;
    acmd.set_ovf = tsts.ovf;
    acmd.cat     = cat_q;
    acmd.len     = len_q;
  end

  biut_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_items (min_items)
  );

  biut_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (tcmd),
    .clear (out_load),
    .sts   (tsts),
    .count (count)
  );

  biut_totals #(
    .CATEGORY_COUNT (CATEGORY_COUNT)
  ) u_totals (
    .clk           (clk),
    .rst           (rst),
    .cmd           (acmd),
    .items_seen    (items_seen),
    .overlap_sum   (overlap_sum),
    .cat_sum       (cat_sum),
    .overflow_seen (overflow_seen)
  );

  // Categories that this configuration does not keep report zero.
  for (genvar k = 0; k < OUT_CATS; k++) begin : g_cat_out
    if (k < CATEGORY_COUNT) begin : g_kept
      assign cat_out[k] = cat_sum[k];
    end else begin : g_zero
      assign cat_out[k] = '0;
    end
  end

  // Result register; it holds a finished batch result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {8'(count), cat_out[4], cat_out[3], cat_out[2], cat_out[1], cat_out[0],
                  overlap_sum, tsts.span, tsts.busy_time};
      m_tuser <= {(items_seen >= min_items) && (tsts.span != '0), overflow_seen};
    end
  end

endmodule

[rtl/biut_checker.sv]
// Port-level checker for the busy interval union tracker, bound to the top level.
`include "busy_interval_union_tracker_macros.svh"

module biut_checker
  import biut_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [RES_W-1:0] m_tdata,
  input logic [1:0]       m_tuser
);

  // The block works on one item at a time, so it is busy right after taking one.
  `BIUT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "item accepted while busy")

  // A valid result needs a positive span.
  `BIUT_ASSERT_IMP(a_valid_span, clk, rst, m_tvalid && m_tuser[1], m_tdata[127:64] != '0, "valid result with zero span")

  // Disjoint intervals can never cover more than the span they lie in.
  `BIUT_ASSERT_IMP(a_union_in_span, clk, rst, m_tvalid, m_tdata[63:0] <= m_tdata[127:64], "union exceeds span")

  // A result that is not taken stays put.
  `BIUT_ASSERT_NEXT(a_result_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind busy_interval_union_tracker biut_checker u_biut_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the busy interval union tracker: directed table, then random batches.
`timescale 1ns / 1ps

module tb;
  import biut_pkg::*;

  localparam int TBL_DEPTH = 128;
  localparam int PHASE_ITEMS = 259;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [TIME_W-1:0] T_MAX = '1;
  // Word index on the configuration port that holds no register; writes there are ignored.
  localparam logic [ADDR_W-3:0] REG_SPARE = 1'b1;

  // One timed command as it travels on the input stream.
  typedef struct {
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic [CAT_W-1:0]  cat;
    logic              skip;
    logic              last;
  } command_t;

  // The batch report carried by one result item.
  typedef struct {
    logic [TIME_W-1:0] busy;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] overlapped;
    logic [TIME_W-1:0] per_cat [OUT_CATS];
    logic [7:0]        intervals;
    logic              dropped;
    logic              valid;
  } busy_report_t;

  // A row of the directed table. Where typed is set, the batch report is known by hand:
  // the listed totals, all other category totals zero, no drop and result_valid low.
  typedef struct {
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic [CAT_W-1:0]  cat;
    logic              skip;
    logic              last;
    logic              typed;
    logic [TIME_W-1:0] w_busy;
    logic [TIME_W-1:0] w_span;
    logic [TIME_W-1:0] w_overlapped;
    logic [TIME_W-1:0] w_kernel;
    logic [7:0]        w_intervals;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [ITEM_W-1:0] s_tdata;  // start_time[63:0], end_time[127:64], category[130:128]
  logic [0:0]        s_tuser;  // skip[0]
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [RES_W-1:0]  m_tdata;  // union, span, overlapped, kernel, write, copy, read, other
                               // (64 bits each), interval_count[519:512]
  logic [1:0]        m_tuser;  // table_overflow[0], result_valid[1]
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  busy_interval_union_tracker #(
    .TABLE_DEPTH   (TBL_DEPTH),
    .CATEGORY_COUNT(OUT_CATS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the tracker state: the interval table, the running totals and the
  // min_items register.
  logic [TIME_W-1:0] ivl_lo [TBL_DEPTH];
  logic [TIME_W-1:0] ivl_hi [TBL_DEPTH];
  int                ivl_count;
  logic [TIME_W-1:0] overlap_total;
  logic [TIME_W-1:0] category_total [OUT_CATS];
  logic [CNT_W-1:0]  items_count;
  logic              dropped_flag;
  logic [CNT_W-1:0]  min_items_setting;

  busy_report_t pending_reports[$];
  busy_report_t oldest_report;
  int           mismatches;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clears everything that belongs to one batch; min_items survives.
  task automatic clear_batch_state();
    ivl_count = 0;
    overlap_total = '0;
    items_count = '0;
    dropped_flag = 1'b0;
    for (int k = 0; k < OUT_CATS; k++) category_total[k] = '0;
  endtask

  // Melds [lo, hi] with every stored interval it touches. Entries that stay apart keep their
  // order and move down; the union goes behind them, or is lost when the table is full.
  task automatic absorb_interval(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
    int kept;
    kept = 0;
    for (int i = 0; i < ivl_count; i++) begin
      if (!(ivl_hi[i] < lo || hi < ivl_lo[i])) begin
        if (ivl_lo[i] < lo) lo = ivl_lo[i];
        if (ivl_hi[i] > hi) hi = ivl_hi[i];
      end else begin
        ivl_lo[kept] = ivl_lo[i];
        ivl_hi[kept] = ivl_hi[i];
        kept++;
      end
    end
    if (kept < TBL_DEPTH) begin
      ivl_lo[kept] = lo;
      ivl_hi[kept] = hi;
      kept++;
    end else begin
      dropped_flag = 1'b1;
    end
    ivl_count = kept;
  endtask

  // Applies one accepted command to the state. On the last command of a batch it works out
  // the batch report and clears the batch.
  task automatic predict_command(input command_t c, output logic emits, output busy_report_t r);
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] len;
    if (items_count != ITEMS_MAX) items_count++;
    if (!c.skip) begin
      lo = (c.t_start > c.t_end) ? c.t_end : c.t_start;
      len = c.t_end - lo;
      absorb_interval(lo, c.t_end);
      overlap_total += len;
      if (c.cat < OUT_CATS) category_total[c.cat] += len;
    end
    emits = c.last;
    if (!c.last) return;
    r.busy = '0;
    lo = '0;
    hi = '0;
    for (int i = 0; i < ivl_count; i++) begin
      if (i == 0 || ivl_lo[i] < lo) lo = ivl_lo[i];
      if (i == 0 || ivl_hi[i] > hi) hi = ivl_hi[i];
      r.busy += ivl_hi[i] - ivl_lo[i];
    end
    r.span = (lo < hi) ? hi - lo : '0;
    r.overlapped = overlap_total;
    for (int k = 0; k < OUT_CATS; k++) r.per_cat[k] = category_total[k];
    r.intervals = 8'(ivl_count);
    r.dropped = dropped_flag;
    r.valid = (items_count >= min_items_setting) && (r.span != '0);
    clear_batch_state();
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offers one command at the falling edge, idling first at the current rate, and holds it
  // until the tracker takes it. Returns at a falling edge where nothing has been driven yet.
  task automatic send_command(input command_t c, input logic typed, input busy_report_t want);
    logic         emits;
    busy_report_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, c.cat, c.t_end, c.t_start};
    s_tuser <= c.skip;
    s_tlast <= c.last;
    do @(posedge clk); while (!s_tready);
    predict_command(c, emits, r);
    if (emits) pending_reports.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // Setup and access phase of one register write; the register takes it at the access edge.
  task automatic write_register(input logic [ADDR_W-3:0] index, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_MIN_ITEMS) min_items_setting = data[CNT_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Reads min_items back and compares it with its reset value or the value we last wrote to it.
  task automatic read_min_items();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_MIN_ITEMS, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("min_items", 64'(min_items_setting), 64'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for every outstanding report, then lets the tracker finish any command still in work.
  task automatic wait_until_idle();
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every accepted result item is held against the oldest outstanding report.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result item with no report outstanding");
        mismatches++;
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("union_busy_time", oldest_report.busy, m_tdata[63:0]);
        check_field("span_time", oldest_report.span, m_tdata[127:64]);
        check_field("overlapped_busy_time", oldest_report.overlapped, m_tdata[191:128]);
        check_field("kernel_busy_time", oldest_report.per_cat[0], m_tdata[255:192]);
        check_field("write_busy_time", oldest_report.per_cat[1], m_tdata[319:256]);
        check_field("copy_busy_time", oldest_report.per_cat[2], m_tdata[383:320]);
        check_field("read_busy_time", oldest_report.per_cat[3], m_tdata[447:384]);
        check_field("other_busy_time", oldest_report.per_cat[4], m_tdata[511:448]);
        check_field("interval_count", 64'(oldest_report.intervals), 64'(m_tdata[519:512]));
        check_field("table_overflow", 64'(oldest_report.dropped), 64'(m_tuser[0]));
        check_field("result_valid", 64'(oldest_report.valid), 64'(m_tuser[1]));
      end
    end
  end

  // A stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    plan_row_t         plan [18];
    command_t          c;
    busy_report_t      want;
    int                sent;
    int                len;
    logic              batch_open;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] spread;
    logic [TIME_W-1:0] swap;
    int                phase_idle [4];
    int                phase_stall [4];
    logic [CNT_W-1:0]  phase_min [4];

    // The directed table. Batches are short, so min_items at its reset value of 50 keeps
    // result_valid low in every typed row.
    plan = '{
      // Skipped last command with extreme fields: empty table, everything zero.
      '{T_MAX, 64'd0, 3'd7, 1'b1, 1'b1, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      // The widest possible interval alone.
      '{64'd0, T_MAX, 3'd0, 1'b0, 1'b1, 1'b1, T_MAX, T_MAX, T_MAX, T_MAX, 8'd1},
      // Start later than end is clamped down to a point.
      '{T_MAX, 64'd5, 3'd1, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd10, 64'd20, 3'd2, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd15, 64'd30, 3'd3, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd100, 64'd200, 3'd4, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd40, 64'd50, 3'd0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      // An out-of-range category that swallows every interval so far.
      '{64'd0, 64'd1000, 3'd5, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd2000, 64'd2001, 3'd6, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{T_MAX - 64'd1, T_MAX, 3'd7, 1'b0, 1'b1, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      // Two full-range commands make the sums wrap around.
      '{64'd0, T_MAX, 3'd0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd0, T_MAX, 3'd0, 1'b0, 1'b1, 1'b1, T_MAX, T_MAX, T_MAX - 64'd1, T_MAX - 64'd1,
        8'd1},
      // A skipped command is counted but not merged; a point interval gives zero span.
      '{64'd3, 64'd9, 3'd2, 1'b1, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd7, 64'd7, 3'd3, 1'b0, 1'b1, 1'b1, 64'd0, 64'd0, 64'd0, 64'd0, 8'd1},
      // Closed intervals that share an end point merge; the next integer does not.
      '{64'd1, 64'd5, 3'd4, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd5, 64'd9, 3'd1, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      '{64'd10, 64'd12, 3'd0, 1'b0, 1'b0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0},
      // A skipped last command still closes the batch.
      '{64'd0, T_MAX, 3'd2, 1'b1, 1'b1, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0}
    };
    phase_idle = '{0, 65, 0, 34};
    phase_stall = '{0, 0, 65, 34};
    phase_min = '{16'd0, 16'hFFFF, 16'd1, 16'(32'($urandom_range(2, 40)))};

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    min_items_setting = MIN_ITEMS_RESET;
    clear_batch_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    read_min_items();
    foreach (plan[i]) begin
      c.t_start = plan[i].t_start;
      c.t_end = plan[i].t_end;
      c.cat = plan[i].cat;
      c.skip = plan[i].skip;
      c.last = plan[i].last;
      want.busy = plan[i].w_busy;
      want.span = plan[i].w_span;
      want.overlapped = plan[i].w_overlapped;
      for (int k = 0; k < OUT_CATS; k++) want.per_cat[k] = '0;
      want.per_cat[0] = plan[i].w_kernel;
      want.intervals = plan[i].w_intervals;
      want.dropped = 1'b0;
      want.valid = 1'b0;
      send_command(c, plan[i].typed, want);
    end
    s_tvalid <= 1'b0;

    // Random phases. Each one starts idle, writes the spare word and min_items (upper data
    // bits random, since only the low half is kept), reads min_items back and then sends
    // batches at its own idle and stall rates.
    for (int phase = 0; phase < 4; phase++) begin
      wait_until_idle();
      send_idle_pct = phase_idle[phase];
      recv_stall_pct = phase_stall[phase];
      write_register(REG_SPARE, $urandom);
      write_register(REG_MIN_ITEMS, {16'($urandom), phase_min[phase]});
      read_min_items();
      sent = 0;
      batch_open = 1'b0;

      // On alternate phases, fill the table past its depth with disjoint intervals so that
      // some are dropped, then merge one more into the full table and close the batch.
      if (phase % 2 == 0) begin
        base = {$urandom, $urandom} >> 1;
        for (int i = 0; i < TBL_DEPTH + 4; i++) begin
          c.t_start = base + 64'(i * 16) + 64'($urandom_range(0, 3));
          c.t_end = c.t_start + 64'($urandom_range(0, 8));
          c.cat = 3'($urandom_range(0, 4));
          c.skip = 1'b0;
          c.last = 1'b0;
          send_command(c, 1'b0, want);
        end
        c.t_start = base;
        c.t_end = base + 64'd2;
        send_command(c, 1'b0, want);
        c.skip = 1'($urandom_range(0, 1));
        c.last = 1'b1;
        send_command(c, 1'b0, want);
        sent += TBL_DEPTH + 6;
      end

      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          // Noise: one command with every field random.
          c.t_start = {$urandom, $urandom};
          c.t_end = {$urandom, $urandom};
          c.cat = 3'($urandom_range(0, 7));
          c.skip = 1'($urandom_range(0, 1));
          c.last = 1'($urandom_range(0, 1));
          send_command(c, 1'b0, want);
          batch_open = !c.last;
          sent++;
        end else begin
          // A well-formed batch: commands clustered around one base so that they overlap,
          // the window width chosen over many orders of magnitude.
          len = $urandom_range(1, 40);
          base = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 5000));
          spread = 64'd1 << $urandom_range(1, 24);
          for (int j = 0; j < len; j++) begin
            c.t_start = base + ({$urandom, $urandom} % spread);
            c.t_end = c.t_start + ({$urandom, $urandom} % ((spread >> 2) + 64'd1));
            if ($urandom_range(0, 9) == 0) begin
              swap = c.t_start;
              c.t_start = c.t_end + 64'd1;
              c.t_end = swap;
            end
            if ($urandom_range(0, 29) == 0) begin
              c.t_start = {$urandom, $urandom};
              c.t_end = {$urandom, $urandom};
            end
            c.cat = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            c.skip = ($urandom_range(0, 9) == 0);
            c.last = (j == len - 1);
            send_command(c, 1'b0, want);
          end
          batch_open = 1'b0;
          sent += len;
        end
      end

      // Close a batch left open by noise so that the phase ends with nothing in flight.
      if (batch_open) begin
        c.t_start = {$urandom, $urandom};
        c.t_end = {$urandom, $urandom};
        c.cat = 3'($urandom_range(0, 7));
        c.skip = 1'($urandom_range(0, 1));
        c.last = 1'b1;
        send_command(c, 1'b0, want);
      end
      s_tvalid <= 1'b0;
    end

    wait_until_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/biut_pkg.sv
rtl/biut_cfg.sv
rtl/biut_totals.sv
rtl/biut_table.sv
rtl/busy_interval_union_tracker.sv
rtl/biut_checker.sv
sim/tb.sv
